/* design/quanta_exchange_monte_carlo_defines.svh */
// ----------------------------------------------------------------------------
// Quanta exchange assertion macros
// Shared property forms for the exchange block; they expect clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef QUANTA_EXCHANGE_MONTE_CARLO_DEFINES_SVH
`define QUANTA_EXCHANGE_MONTE_CARLO_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define QXMC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define QXMC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/qxmc_pkg.sv */
// ----------------------------------------------------------------------------
// Quanta exchange package
// Sizes, codes, state encoding and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qxmc_pkg;

  localparam int NUM_OBJECTS = 1024;
  localparam int NUM_LEVELS  = 64;

  localparam int OBJ_AW    = $clog2(NUM_OBJECTS);
  localparam int LVL_AW    = $clog2(NUM_LEVELS);
  localparam int HIST_W    = $clog2(NUM_OBJECTS + 1);
  localparam int HALF      = NUM_OBJECTS / 2;
  localparam int FILL_LEN  = (NUM_OBJECTS > NUM_LEVELS) ? NUM_OBJECTS : NUM_LEVELS;
  localparam int FILL_W    = $clog2(FILL_LEN);

  localparam int ENERGY_W  = 13;
  localparam int CNT_W     = 32;
  localparam int IDX_W     = 10;
  localparam int LEVEL_W   = 6;
  localparam int OP_W      = 2;
  localparam int MODE_W    = 2;
  localparam int OUT_CNT_W = 11;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 13'd8191;

  // request opcodes
  localparam logic [OP_W-1:0] OP_EXCHANGE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_LEVEL = 2'd1;
  localparam logic [OP_W-1:0] OP_REFILL     = 2'd2;

  // fill patterns
  localparam logic [MODE_W-1:0] MODE_SPLIT_73 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPLIT_46 = 2'd2;

  localparam logic [ENERGY_W-1:0] E_UNIFORM = 13'd5;
  localparam logic [ENERGY_W-1:0] E_SEVEN   = 13'd7;
  localparam logic [ENERGY_W-1:0] E_THREE   = 13'd3;
  localparam logic [ENERGY_W-1:0] E_FOUR    = 13'd4;
  localparam logic [ENERGY_W-1:0] E_SIX     = 13'd6;

  // histogram bins touched by one kept exchange, in update order
  typedef enum logic [1:0] {
    BIN_DN_OLD,
    BIN_DN_NEW,
    BIN_RX_OLD,
    BIN_RX_NEW
  } bin_sel_t;

  typedef enum logic [3:0] {
    ST_INIT_FILL,
    ST_IDLE,
    ST_DECODE,
    ST_RD_RX,
    ST_CHK,
    ST_JUDGE,
    ST_WR_RX,
    ST_H_RD,
    ST_H_WR,
    ST_LVL_CAP,
    ST_REFILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     ld_item;
    logic     fill_start;
    logic     fill_we;
    logic     e_rd_rx;
    logic     cap_dn;
    logic     cap_rx;
    logic     e_we_dn;
    logic     e_we_rx;
    logic     set_moved;
    logic     cnt_kept;
    logic     cnt_rej;
    logic     h_rd_level;
    logic     h_wr;
    bin_sel_t bin_sel;
    logic     cap_lcount;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_ok;
    logic            same_idx;
    logic            move_ok;
    logic            lvl_ok;
    logic            fill_last;
    logic            out_free;
  } dp_sts_t;

endpackage

/* design/qxmc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qxmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/qxmc_ctrl.sv */
// ----------------------------------------------------------------------------
// Quanta exchange controller
// Sequences fill sweeps, exchanges, level reads and the result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qxmc_ctrl
  import qxmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t   state_r, state_nxt;
  bin_sel_t bin_r, bin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_FILL;
      bin_r   <= BIN_DN_OLD;
    end else begin
      state_r <= state_nxt;
      bin_r   <= bin_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    unique case (state_r)
      ST_INIT_FILL: begin
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_EXCHANGE: begin
            if (!sts.idx_ok || sts.same_idx) state_nxt = ST_DONE;
            else state_nxt = ST_RD_RX;
          end
          OP_READ_LEVEL: begin
            state_nxt = sts.lvl_ok ? ST_LVL_CAP : ST_DONE;
          end
          OP_REFILL: begin
            state_nxt = ST_REFILL;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_RD_RX:   state_nxt = ST_CHK;
      ST_CHK:     state_nxt = ST_JUDGE;
      ST_JUDGE: begin
        state_nxt = sts.move_ok ? ST_WR_RX : ST_DONE;
      end
      ST_WR_RX: begin
        bin_nxt   = BIN_DN_OLD;
        state_nxt = ST_H_RD;
      end
      ST_H_RD:    state_nxt = ST_H_WR;
      ST_H_WR: begin
        unique case (bin_r)
          BIN_DN_OLD: begin
            bin_nxt   = BIN_DN_NEW;
            state_nxt = ST_H_RD;
          end
          BIN_DN_NEW: begin
            bin_nxt   = BIN_RX_OLD;
            state_nxt = ST_H_RD;
          end
          BIN_RX_OLD: begin
            bin_nxt   = BIN_RX_NEW;
            state_nxt = ST_H_RD;
          end
          BIN_RX_NEW: begin
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_LVL_CAP: state_nxt = ST_DONE;
      ST_REFILL: begin
        if (sts.fill_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT_FILL: cmd.fill_we = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.ld_item = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_EXCHANGE: begin
            if (!sts.idx_ok) begin
              cmd.cnt_rej = 1'b1;
            end else if (sts.same_idx) begin
              cmd.cnt_kept  = 1'b1;
              cmd.set_moved = 1'b1;
            end
          end
          OP_READ_LEVEL: cmd.h_rd_level = 1'b1;
          OP_REFILL:     cmd.fill_start = 1'b1;
          default: ;
        endcase
      end
      ST_RD_RX: begin
        cmd.e_rd_rx = 1'b1;
        cmd.cap_dn  = 1'b1;
      end
      ST_CHK: cmd.cap_rx = 1'b1;
      ST_JUDGE: begin
        if (sts.move_ok) begin
          cmd.e_we_dn   = 1'b1;
          cmd.set_moved = 1'b1;
          cmd.cnt_kept  = 1'b1;
        end else begin
          cmd.cnt_rej = 1'b1;
        end
      end
      ST_WR_RX: cmd.e_we_rx = 1'b1;
      ST_H_RD: cmd.bin_sel = bin_r;
      ST_H_WR: begin
        cmd.bin_sel = bin_r;
        cmd.h_wr    = 1'b1;
      end
      ST_LVL_CAP: cmd.cap_lcount = 1'b1;
      ST_REFILL:  cmd.fill_we = 1'b1;
      ST_DONE:    cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* design/qxmc_dp.sv */
// ----------------------------------------------------------------------------
// Quanta exchange datapath
// Energy store, level histogram, step counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quanta_exchange_monte_carlo_defines.svh"

module qxmc_dp
  import qxmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [MODE_W-1:0]    cfg_wdata,
  input  logic [OP_W-1:0]      in_op,
  input  logic [IDX_W-1:0]     in_receiver_index,
  input  logic [IDX_W-1:0]     in_donor_index,
  input  logic [LEVEL_W-1:0]   in_level,
  input  logic                 out_ready,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  output logic                 out_moved,
  output logic [OUT_CNT_W-1:0] out_zero_count,
  output logic [CNT_W-1:0]     out_effective_steps,
  output logic [CNT_W-1:0]     out_rejected_steps,
  output logic [OUT_CNT_W-1:0] out_level_count
);

  // captured request
  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   rx_r;
  logic [IDX_W-1:0]   dn_r;
  logic [LEVEL_W-1:0] level_r;

  logic [MODE_W-1:0]   mode_r;
  logic [MODE_W-1:0]   fill_mode_r;
  logic [FILL_W-1:0]   fill_idx_r, fill_idx_nxt;
  logic [ENERGY_W-1:0] e_dn_r;
  logic [ENERGY_W-1:0] e_rx_r;
  logic                moved_r;
  logic [HIST_W-1:0]   lcount_r;
  logic [CNT_W-1:0]    kept_r, kept_nxt;
  logic [CNT_W-1:0]    rej_r, rej_nxt;
  logic [HIST_W-1:0]   zero_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_moved_r;
  logic [OUT_CNT_W-1:0] out_zero_r;
  logic [CNT_W-1:0]     out_eff_r;
  logic [CNT_W-1:0]     out_rej_r;
  logic [OUT_CNT_W-1:0] out_lcount_r;

  logic [ENERGY_W-1:0] fill_lo, fill_hi, fill_energy;
  logic [HIST_W-1:0]   fill_count;
  logic                fill_in_obj, fill_in_lvl;

  logic                e_we;
  logic [OBJ_AW-1:0]   e_waddr, e_raddr;
  logic [ENERGY_W-1:0] e_wdata, e_rdata;

  logic [ENERGY_W-1:0] bin_val;
  logic                bin_up, bin_tracked;
  logic                h_we;
  logic [LVL_AW-1:0]   h_waddr, h_raddr;
  logic [HIST_W-1:0]   h_wdata, h_rdata, h_upd;

  // fill pattern
  always_comb begin
    unique case (fill_mode_r)
      MODE_SPLIT_73: begin
        fill_lo = E_SEVEN;
        fill_hi = E_THREE;
      end
      MODE_SPLIT_46: begin
        fill_lo = E_FOUR;
        fill_hi = E_SIX;
      end
      default: begin
        fill_lo = E_UNIFORM;
        fill_hi = E_UNIFORM;
      end
    endcase
  end

  assign fill_energy = (32'(fill_idx_r) < 32'(HALF)) ? fill_lo : fill_hi;
  assign fill_count  = ((32'(fill_idx_r) == 32'(fill_lo)) ? HIST_W'(HALF) : '0)
                     + ((32'(fill_idx_r) == 32'(fill_hi)) ? HIST_W'(NUM_OBJECTS - HALF) : '0);
  assign fill_in_obj = 32'(fill_idx_r) < 32'(NUM_OBJECTS);
  assign fill_in_lvl = 32'(fill_idx_r) < 32'(NUM_LEVELS);

  always_comb begin
    fill_idx_nxt = fill_idx_r;
    if (cmd.fill_start) begin
      fill_idx_nxt = '0;
    end else if (cmd.fill_we) begin
      fill_idx_nxt = sts.fill_last ? '0 : fill_idx_r + FILL_W'(1);
    end
  end

  // energy store port muxing
  assign e_raddr = cmd.e_rd_rx ? OBJ_AW'(rx_r) : OBJ_AW'(dn_r);
  assign e_we    = (cmd.fill_we && fill_in_obj) || cmd.e_we_dn || cmd.e_we_rx;

  always_comb begin
    priority if (cmd.fill_we) begin
      e_waddr = OBJ_AW'(fill_idx_r);
      e_wdata = fill_energy;
    end else if (cmd.e_we_rx) begin
      e_waddr = OBJ_AW'(rx_r);
      e_wdata = e_rx_r + ENERGY_W'(1);
    end else begin
      e_waddr = OBJ_AW'(dn_r);
      e_wdata = e_dn_r - ENERGY_W'(1);
    end
  end

  qxmc_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (NUM_OBJECTS)
  ) u_energy_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // histogram bin under update
  always_comb begin
    unique case (cmd.bin_sel)
      BIN_DN_OLD: bin_val = e_dn_r;
      BIN_DN_NEW: bin_val = e_dn_r - ENERGY_W'(1);
      BIN_RX_OLD: bin_val = e_rx_r;
      BIN_RX_NEW: bin_val = e_rx_r + ENERGY_W'(1);
      default:    bin_val = e_dn_r;
    endcase
  end

  assign bin_up      = (cmd.bin_sel == BIN_DN_NEW) || (cmd.bin_sel == BIN_RX_NEW);
  assign bin_tracked = 32'(bin_val) < 32'(NUM_LEVELS);
  assign h_upd       = bin_up ? h_rdata + HIST_W'(1)
                     : ((h_rdata != '0) ? h_rdata - HIST_W'(1) : h_rdata);

  assign h_raddr = cmd.h_rd_level ? LVL_AW'(level_r) : LVL_AW'(bin_val);
  assign h_we    = (cmd.fill_we && fill_in_lvl) || (cmd.h_wr && bin_tracked);
  assign h_waddr = cmd.fill_we ? LVL_AW'(fill_idx_r) : LVL_AW'(bin_val);
  assign h_wdata = cmd.fill_we ? fill_count : h_upd;

  qxmc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (NUM_LEVELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // saturating step counters
  always_comb begin
    kept_nxt = kept_r;
    rej_nxt  = rej_r;
    if (cmd.fill_start) begin
      kept_nxt = '0;
      rej_nxt  = '0;
    end else begin
      if (cmd.cnt_kept && (kept_r != '1)) kept_nxt = kept_r + CNT_W'(1);
      if (cmd.cnt_rej && (rej_r != '1))   rej_nxt  = rej_r + CNT_W'(1);
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      fill_mode_r <= '0;
      fill_idx_r  <= '0;
      kept_r      <= '0;
      rej_r       <= '0;
      zero_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      if (cmd.fill_start) fill_mode_r <= mode_r;
      fill_idx_r  <= fill_idx_nxt;
      kept_r      <= kept_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.fill_start) begin
        zero_r <= '0;
      end else if (cmd.h_wr && bin_tracked && (bin_val == '0)) begin
        zero_r <= h_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      op_r    <= in_op;
      rx_r    <= in_receiver_index;
      dn_r    <= in_donor_index;
      level_r <= in_level;
    end
    if (cmd.cap_dn) e_dn_r <= e_rdata;
    if (cmd.cap_rx) e_rx_r <= e_rdata;
    if (cmd.ld_item) begin
      moved_r <= 1'b0;
    end else if (cmd.set_moved) begin
      moved_r <= 1'b1;
    end
    if (cmd.ld_item) begin
      lcount_r <= '0;
    end else if (cmd.cap_lcount) begin
      lcount_r <= h_rdata;
    end
    if (cmd.out_load) begin
      out_moved_r  <= moved_r;
      out_zero_r   <= OUT_CNT_W'(zero_r);
      out_eff_r    <= kept_r;
      out_rej_r    <= rej_r;
      out_lcount_r <= OUT_CNT_W'(lcount_r);
    end
  end

  assign sts.op        = op_r;
  assign sts.idx_ok    = (32'(rx_r) < 32'(NUM_OBJECTS)) && (32'(dn_r) < 32'(NUM_OBJECTS));
  assign sts.same_idx  = (rx_r == dn_r);
  assign sts.move_ok   = (e_dn_r != '0) && (e_rx_r != ENERGY_MAX);
  assign sts.lvl_ok    = 32'(level_r) < 32'(NUM_LEVELS);
  assign sts.fill_last = (fill_idx_r == FILL_W'(FILL_LEN - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_moved           = out_moved_r;
  assign out_zero_count      = out_zero_r;
  assign out_effective_steps = out_eff_r;
  assign out_rejected_steps  = out_rej_r;
  assign out_level_count     = out_lcount_r;

  `QXMC_ASSERT_SAME(a_single_count, cmd.cnt_kept, !cmd.cnt_rej, "step counted as kept and rejected")
  `QXMC_ASSERT_SAME(a_donor_not_empty, cmd.e_we_dn, e_dn_r != '0, "quantum taken from empty donor")
  `QXMC_ASSERT_SAME(a_rx_not_full, cmd.e_we_rx, e_rx_r != ENERGY_MAX, "receiver pushed past max")
  `QXMC_ASSERT_NEXT(a_refill_clears, cmd.fill_start, (kept_r == '0) && (rej_r == '0) && (zero_r == '0), "refill left counters set")
  `QXMC_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r, "result load did not raise valid")

endmodule

/* design/quanta_exchange_monte_carlo.sv */
// ----------------------------------------------------------------------------
// Quanta exchange Monte Carlo
// Energy-exchange stepper over an Einstein solid with a level histogram.
//
//   channel   ports                                  handshake
//   input     in_op, in_*_index, in_level            in_valid / in_ready
//   result    out_moved, out_*_steps, out_*_count    out_valid / out_ready
//   config    cfg_wdata (init_mode)                  cfg_we, no wait
//
// After reset a fill sweep over max(NUM_OBJECTS, NUM_LEVELS) entries (1024) runs
// with in_ready low; refill requests run the same sweep.
// One request at a time; a kept exchange does a histogram read-modify-write
// for each bin that it touches.
// A pending result in the output register does not block the next request;
// a stalled result holds the following one in its final state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quanta_exchange_monte_carlo
  import qxmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [MODE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_op,
  input  logic [IDX_W-1:0]     in_receiver_index,
  input  logic [IDX_W-1:0]     in_donor_index,
  input  logic [LEVEL_W-1:0]   in_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_moved,
  output logic [OUT_CNT_W-1:0] out_zero_count,
  output logic [CNT_W-1:0]     out_effective_steps,
  output logic [CNT_W-1:0]     out_rejected_steps,
  output logic [OUT_CNT_W-1:0] out_level_count
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  qxmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qxmc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_op),
    .in_receiver_index   (in_receiver_index),
    .in_donor_index      (in_donor_index),
    .in_level            (in_level),
    .out_ready           (out_ready),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_moved           (out_moved),
    .out_zero_count      (out_zero_count),
    .out_effective_steps (out_effective_steps),
    .out_rejected_steps  (out_rejected_steps),
    .out_level_count     (out_level_count)
  );

endmodule
